@@ design/lisr_pkg.sv @@
// Shared constants and types for the linear-interpolation stereo resampler.
`timescale 1ns / 1ps
`default_nettype none

package lisr_pkg;

   localparam int SAMPLE_BITS_DEF = 24;
   localparam int FRAC_BITS_DEF   = 24;
   // Integer bits kept above the binary point of the read position.
   localparam int PHASE_INT_BITS  = 4;
   // Most output frames one input frame may produce.
   localparam int MAX_RUN         = 6;
   localparam int CNT_BITS        = $clog2(MAX_RUN + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MUL_L,
      ST_MUL_R,
      ST_RND_R,
      ST_PUSH
   } seq_state_type;

endpackage : lisr_pkg

`default_nettype wire

@@ design/linear_interp_stereo_resampler_core.sv @@
// Top level: linear-interpolation stereo resampler with one shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

// Linear-interpolation stereo resampler. Each accepted request is one stereo
// frame; the core holds the previous frame and a read position with FRAC_BITS
// fraction bits, and emits prev + (cur - prev) * frac per channel while the
// position is below 1.0, advancing it by csr_phase_step each time. The first
// frame after reset is only stored when the step is not 1.0, a position of
// 1.0 or more skips the frame, and a step of exactly 1.0 passes frames through
// unchanged. req_stall is high while a frame is being worked on. A frame gives
// at most 6 results, and each may wait in the push step on rsp_stall. One
// multiplier is shared by both channels: the left product is formed, then the
// right product while the left is rounded, then the right is rounded. The
// result register lets the next request be taken while the last result is
// still waiting.
module linear_interp_stereo_resampler_core
   import lisr_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_we,
   input  wire logic [FRAC_BITS+PHASE_INT_BITS-1:0]   csr_phase_step,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_left_in,
   input  wire logic signed [SAMPLE_BITS-1:0]         req_right_in,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic signed [SAMPLE_BITS-1:0]              rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]              rsp_right_out,
   output logic                                       rsp_run_last
);

   localparam int PHASE_W = FRAC_BITS + PHASE_INT_BITS;
   localparam int DIFF_W  = SAMPLE_BITS + 1;
   localparam int PROD_W  = SAMPLE_BITS + FRAC_BITS + 1;
   localparam logic [PHASE_W-1:0]  ONE_PH   = PHASE_W'(1) << FRAC_BITS;
   localparam logic [PROD_W-1:0]   HALF     = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [CNT_BITS-1:0] MAX_CNT  = CNT_BITS'(MAX_RUN);
   localparam logic [CNT_BITS-1:0] LAST_CNT = CNT_BITS'(MAX_RUN - 1);

   seq_state_type state_ff, state_in;

   logic [PHASE_W-1:0]     step_ff, step_in;
   logic [PHASE_W-1:0]     phase_ff, phase_in;
   logic [CNT_BITS-1:0]    count_ff, count_in;
   logic                   have_prev_ff, have_prev_in;
   logic                   pass_ff, pass_in;
   logic [SAMPLE_BITS-1:0] prev_l_ff, prev_l_in;
   logic [SAMPLE_BITS-1:0] prev_r_ff, prev_r_in;
   logic [SAMPLE_BITS-1:0] cur_l_ff, cur_l_in;
   logic [SAMPLE_BITS-1:0] cur_r_ff, cur_r_in;
   logic [SAMPLE_BITS-1:0] res_l_ff, res_l_in;
   logic [SAMPLE_BITS-1:0] res_r_ff, res_r_in;
   logic [PROD_W-1:0]      prod_ff, prod_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_l_ff, rsp_l_in;
   logic [SAMPLE_BITS-1:0] rsp_r_ff, rsp_r_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                      req_take;
   logic                      slot_free;
   logic                      below_one;
   logic [PHASE_W-1:0]        phase_sum;
   logic                      last_of_run;
   logic [DIFF_W-1:0]         diff;
   logic signed [PROD_W:0]    mul_full;
   logic [PROD_W-1:0]         rnd_sum;
   logic [DIFF_W-1:0]         rnd_q;
   logic [SAMPLE_BITS-1:0]    prev_sel;
   logic [DIFF_W-1:0]         interp_full;

   // Shared datapath: the channel is chosen by the sequencer state.
   always_comb begin
      if (state_ff == ST_MUL_R) begin
         diff = {cur_r_ff[SAMPLE_BITS-1], cur_r_ff} - {prev_r_ff[SAMPLE_BITS-1], prev_r_ff};
         prev_sel = prev_l_ff;
      end else begin
         diff = {cur_l_ff[SAMPLE_BITS-1], cur_l_ff} - {prev_l_ff[SAMPLE_BITS-1], prev_l_ff};
         prev_sel = prev_r_ff;
      end
   end

   assign mul_full    = $signed(diff) * $signed({1'b0, phase_ff[FRAC_BITS-1:0]});
   assign rnd_sum     = prod_ff + HALF;
   assign rnd_q       = rnd_sum[PROD_W-1:FRAC_BITS];
   assign interp_full = rnd_q + {prev_sel[SAMPLE_BITS-1], prev_sel};

   assign below_one   = (phase_ff[PHASE_W-1:FRAC_BITS] == '0);
   assign phase_sum   = phase_ff + step_ff;
   assign last_of_run = pass_ff || (phase_sum[PHASE_W-1:FRAC_BITS] != '0) ||
                        (count_ff == LAST_CNT);

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      step_in      = csr_we ? csr_phase_step : step_ff;
      phase_in     = phase_ff;
      count_in     = count_ff;
      have_prev_in = have_prev_ff;
      pass_in      = pass_ff;
      prev_l_in    = prev_l_ff;
      prev_r_in    = prev_r_ff;
      cur_l_in     = cur_l_ff;
      cur_r_in     = cur_r_ff;
      res_l_in     = res_l_ff;
      res_r_in     = res_r_ff;
      prod_in      = prod_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_l_in     = rsp_l_ff;
      rsp_r_in     = rsp_r_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (step_ff == ONE_PH) begin
                  res_l_in     = req_left_in;
                  res_r_in     = req_right_in;
                  prev_l_in    = req_left_in;
                  prev_r_in    = req_right_in;
                  have_prev_in = 1'b1;
                  pass_in      = 1'b1;
                  state_in     = ST_PUSH;
               end else if (!have_prev_ff) begin
                  prev_l_in    = req_left_in;
                  prev_r_in    = req_right_in;
                  have_prev_in = 1'b1;
               end else begin
                  cur_l_in = req_left_in;
                  cur_r_in = req_right_in;
                  count_in = '0;
                  pass_in  = 1'b0;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (below_one && (count_ff != MAX_CNT)) begin
               state_in = ST_MUL_L;
            end else begin
               // End of frame: a capped run drops the position to zero.
               phase_in  = below_one ? '0 : (phase_ff - ONE_PH);
               prev_l_in = cur_l_ff;
               prev_r_in = cur_r_ff;
               state_in  = ST_IDLE;
            end
         end
         ST_MUL_L: begin
            prod_in  = mul_full[PROD_W-1:0];
            state_in = ST_MUL_R;
         end
         ST_MUL_R: begin
            prod_in  = mul_full[PROD_W-1:0];
            res_l_in = interp_full[SAMPLE_BITS-1:0];
            state_in = ST_RND_R;
         end
         ST_RND_R: begin
            res_r_in = interp_full[SAMPLE_BITS-1:0];
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_l_in     = res_l_ff;
               rsp_r_in     = res_r_ff;
               rsp_last_in  = last_of_run;
               if (pass_ff) begin
                  pass_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  phase_in = phase_sum;
                  count_in = count_ff + CNT_BITS'(1);
                  state_in = ST_CHECK;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= ONE_PH;
         phase_ff     <= '0;
         count_ff     <= '0;
         have_prev_ff <= 1'b0;
         pass_ff      <= 1'b0;
         prev_l_ff    <= '0;
         prev_r_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         have_prev_ff <= have_prev_in;
         pass_ff      <= pass_in;
         prev_l_ff    <= prev_l_in;
         prev_r_ff    <= prev_r_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_l_ff    <= cur_l_in;
      cur_r_ff    <= cur_r_in;
      res_l_ff    <= res_l_in;
      res_r_ff    <= res_r_in;
      prod_ff     <= prod_in;
      rsp_l_ff    <= rsp_l_in;
      rsp_r_ff    <= rsp_r_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = rsp_l_ff;
   assign rsp_right_out = rsp_r_ff;
   assign rsp_run_last  = rsp_last_ff;

   // A new result transaction only ever comes from the push step.
   a_rsp_from_push: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff) |-> $past(state_ff) == ST_PUSH))
      else $error("result appeared outside push step");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= MAX_CNT))
      else $error("output run count above cap");

   // Interpolation only starts with the read position below 1.0.
   a_mul_frac: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL_L |-> below_one && !pass_ff))
      else $error("multiply started with position at or above 1.0");

   a_pass_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PUSH && slot_free && pass_ff |=> state_ff == ST_IDLE && rsp_run_last))
      else $error("pass-through frame not closed as a single result");

endmodule : linear_interp_stereo_resampler_core

`default_nettype wire
